FILE: design/hkst_pkg.sv
// ----------------------------------------------------------------------------
// Hashed key sorted table package
// Shared types, codes and constants for the hashed key sorted table unit.
// ----------------------------------------------------------------------------
package hkst_pkg;

   // Defaults for the top-level parameters.
   localparam int DefMaxEntries  = 256;
   localparam int DefMaxKeyBytes = 128;
   localparam int DefHandleBits  = 16;

   // FNV-1a 64-bit constants.
   localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;

   // Request command codes.
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // Response status codes.
   localparam logic [2:0] ST_CLEARED  = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_TOO_LONG = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;
   localparam logic [2:0] ST_HIT      = 3'd6;
   localparam logic [2:0] ST_MISS     = 3'd7;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_INSERT,
      KIND_LOOKUP
   } kind_type;

   // A completed key handed from the front part to the back part.
   typedef struct packed {
      kind_type    kind;
      logic [63:0] hash;
      logic        empty_key;
      logic        too_long;
      logic [15:0] handle;
   } job_type;

   // One response transaction.
   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  position;
      logic [15:0] found_handle;
      logic [63:0] hash;
      logic [8:0]  entry_count;
   } rsp_type;

   // FNV prime multiply: the prime is 2^40 + 0x1B3, so it is a sum of shifts.
   function automatic logic [63:0] fnv_mul(input logic [63:0] h);
      fnv_mul = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
   endfunction

endpackage

FILE: design/hkst_fifo.sv
// ----------------------------------------------------------------------------
// Hashed key sorted table two-entry queue
// A small queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module hkst_fifo #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/hkst_front.sv
// ----------------------------------------------------------------------------
// Hashed key sorted table front part
// Accepts key bytes, folds them into the FNV-1a hash and emits completed keys.
// ----------------------------------------------------------------------------
module hkst_front
   import hkst_pkg::*;
#(
   parameter int MAX_KEY_BYTES = DefMaxKeyBytes,
   parameter int HANDLE_BITS   = DefHandleBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_key_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   input  logic [15:0] req_value_handle,
   output logic        job_push,
   output job_type     job_data,
   input  logic        job_full
);

   localparam logic [31:0] HandleMask = 32'((64'd1 << HANDLE_BITS) - 64'd1);
   localparam logic [7:0]  KeyLimit   = 8'(MAX_KEY_BYTES);

   logic [63:0] hash_ff, hash_in;
   logic [7:0]  bcnt_ff, bcnt_in;
   logic        long_ff, long_in;
   logic        accept;
   logic [63:0] hash_next;
   logic [7:0]  bcnt_next;
   logic        long_next;

   assign req_full = job_full;
   assign accept   = req_push && !job_full;

   // Fold the byte into the key state and build the job on the last byte or on a clear.
   always_comb begin
      hash_next = hash_ff;
      bcnt_next = bcnt_ff;
      long_next = long_ff;
      if (req_byte_valid) begin
         hash_next = fnv_mul(hash_ff ^ {56'd0, req_key_byte});
         if (bcnt_ff >= KeyLimit) begin
            long_next = 1'b1;
         end
         if (bcnt_ff != 8'hFF) begin
            bcnt_next = bcnt_ff + 8'd1;
         end
      end

      hash_in  = hash_ff;
      bcnt_in  = bcnt_ff;
      long_in  = long_ff;
      job_push = 1'b0;
      job_data.kind      = KIND_CLEAR;
      job_data.hash      = hash_next;
      job_data.empty_key = (bcnt_next == 8'd0);
      job_data.too_long  = long_next;
      job_data.handle    = req_value_handle & HandleMask[15:0];

      if (accept) begin
         case (req_command)
            CMD_CLEAR: begin
               job_push = 1'b1;
               hash_in  = FNV_BASIS;
               bcnt_in  = 8'd0;
               long_in  = 1'b0;
            end
            CMD_INSERT, CMD_LOOKUP: begin
               job_data.kind = (req_command == CMD_INSERT) ? KIND_INSERT : KIND_LOOKUP;
               if (req_last_byte) begin
                  job_push = 1'b1;
                  hash_in  = FNV_BASIS;
                  bcnt_in  = 8'd0;
                  long_in  = 1'b0;
               end else begin
                  hash_in = hash_next;
                  bcnt_in = bcnt_next;
                  long_in = long_next;
               end
            end
            default: begin
               // The unused command leaves everything alone.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
         bcnt_ff <= 8'd0;
         long_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         bcnt_ff <= bcnt_in;
         long_ff <= long_in;
      end
   end

endmodule

FILE: design/hkst_back.sv
// ----------------------------------------------------------------------------
// Hashed key sorted table back part
// Searches and updates the sorted table for each completed key.
// ----------------------------------------------------------------------------
module hkst_back
   import hkst_pkg::*;
#(
   parameter int MAX_ENTRIES = DefMaxEntries
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_empty,
   input  job_type job_data,
   output logic    job_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

   typedef enum logic [3:0] {
      S_IDLE, S_PROBE, S_CMPR, S_MREAD, S_MCHK, S_SHRD, S_SHWR, S_PUT, S_EMIT
   } state_type;

   state_type   state_ff, state_in;
   job_type     job_ff, job_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;
   rsp_type     rsp_ff, rsp_in;

   // Table memory with one write and one registered read port.
   logic [63:0] hash_mem [MAX_ENTRIES];
   logic [15:0] handle_mem [MAX_ENTRIES];
   logic [63:0] rd_hash_ff;
   logic [15:0] rd_handle_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        wr_en;
   logic [63:0] wr_hash;
   logic [15:0] wr_handle;

   logic [CW-1:0] half, mid;
   logic        match;
   logic [31:0] first_wide, used_wide;

   assign half       = cnt_ff >> 1;
   assign mid        = first_ff + half;
   assign match      = (first_ff < used_ff) && (rd_hash_ff == job_ff.hash);
   assign first_wide = 32'(first_ff);

   // Sequencer: a clear empties the table; otherwise binary search, then the insert shift or the lookup result.
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      rsp_in    = rsp_ff;
      job_pop   = 1'b0;
      rsp_push  = 1'b0;
      rd_addr   = mid[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_hash   = rd_hash_ff;
      wr_handle = rd_handle_ff;
      used_wide = 32'(used_ff);

      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               first_in = '0;
               cnt_in   = used_ff;
               if (job_data.kind == KIND_CLEAR) begin
                  used_in = '0;
                  rsp_in  = '0;
                  state_in = S_EMIT;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (cnt_ff == '0) begin
               state_in = S_MREAD;
            end else begin
               state_in = S_CMPR;
            end
         end
         S_CMPR: begin
            if (rd_hash_ff < job_ff.hash) begin
               first_in = mid + CW'(1);
               cnt_in   = cnt_ff - half - CW'(1);
            end else begin
               cnt_in = half;
            end
            state_in = S_PROBE;
         end
         S_MREAD: begin
            rd_addr  = first_ff[AW-1:0];
            state_in = S_MCHK;
         end
         S_MCHK: begin
            rsp_in.position     = first_wide[8:0];
            rsp_in.found_handle = '0;
            rsp_in.hash         = job_ff.hash;
            rsp_in.entry_count  = used_wide[8:0];
            state_in            = S_EMIT;
            if (job_ff.empty_key) begin
               rsp_in.status = ST_EMPTY;
            end else if (job_ff.kind == KIND_INSERT) begin
               if (job_ff.too_long) begin
                  rsp_in.status = ST_TOO_LONG;
               end else if (match) begin
                  rsp_in.status = ST_DUP;
               end else if (used_ff >= MaxCount) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  idx_in   = used_ff;
                  state_in = S_SHRD;
               end
            end else if (match) begin
               rsp_in.status       = ST_HIT;
               rsp_in.found_handle = rd_handle_ff;
            end else begin
               rsp_in.status = ST_MISS;
            end
         end
         S_SHRD: begin
            rd_addr = AW'(idx_ff - CW'(1));
            if (idx_ff == first_ff) begin
               state_in = S_PUT;
            end else begin
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = S_SHRD;
         end
         S_PUT: begin
            wr_en     = 1'b1;
            wr_addr   = first_ff[AW-1:0];
            wr_hash   = job_ff.hash;
            wr_handle = job_ff.handle;
            used_in   = used_ff + CW'(1);
            used_wide = 32'(used_ff + CW'(1));
            rsp_in.status      = ST_INSERTED;
            rsp_in.entry_count = used_wide[8:0];
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
      job_ff   <= job_in;
      first_ff <= first_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   // Table memory access.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hash_mem[wr_addr]   <= wr_hash;
         handle_mem[wr_addr] <= wr_handle;
      end
      rd_hash_ff   <= hash_mem[rd_addr];
      rd_handle_ff <= handle_mem[rd_addr];
   end

endmodule

FILE: design/hashed_key_sorted_table_unit.sv
// ----------------------------------------------------------------------------
// Hashed key sorted table unit
// Hashes streamed keys with FNV-1a and keeps a table sorted by hash.
// ----------------------------------------------------------------------------
// Key bytes are taken one per cycle while the two-entry job queue has room;
// once two completed keys wait there, every byte stalls. A key's last byte
// hands a job to the table sequencer, which runs the binary search, the check
// and the hand-off to the response queue; an insert also shifts later entries
// up one at a time, since the table memory has a single read and a single
// write port. Bytes of the next key keep streaming in while a job is in the
// sequencer.
module hashed_key_sorted_table_unit
   import hkst_pkg::*;
#(
   parameter int MAX_ENTRIES   = DefMaxEntries,
   parameter int MAX_KEY_BYTES = DefMaxKeyBytes,
   parameter int HANDLE_BITS   = DefHandleBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_key_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   input  logic [15:0] req_value_handle,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [8:0]  rsp_position,
   output logic [15:0] rsp_found_handle,
   output logic [63:0] rsp_hash_out,
   output logic [8:0]  rsp_entry_count
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in_data, job_out_data;
   logic    rq_push, rq_full;
   rsp_type rq_in_data, rq_out_data;

   // Key hashing front part.
   hkst_front #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES),
      .HANDLE_BITS  (HANDLE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_command     (req_command),
      .req_key_byte    (req_key_byte),
      .req_byte_valid  (req_byte_valid),
      .req_last_byte   (req_last_byte),
      .req_value_handle(req_value_handle),
      .job_push        (job_push),
      .job_data        (job_in_data),
      .job_full        (job_full)
   );

   // Queue of completed keys.
   hkst_fifo #(.item_type(job_type)) u_job_q (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(job_in_data),
      .full     (job_full),
      .pop      (job_pop),
      .pop_data (job_out_data),
      .empty    (job_empty)
   );

   // Table sequencer.
   hkst_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .job_empty(job_empty),
      .job_data (job_out_data),
      .job_pop  (job_pop),
      .rsp_push (rq_push),
      .rsp_data (rq_in_data),
      .rsp_full (rq_full)
   );

   // Response queue.
   hkst_fifo #(.item_type(rsp_type)) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (rq_push),
      .push_data(rq_in_data),
      .full     (rq_full),
      .pop      (rsp_pop),
      .pop_data (rq_out_data),
      .empty    (rsp_empty)
   );

   assign rsp_status       = rq_out_data.status;
   assign rsp_position     = rq_out_data.position;
   assign rsp_found_handle = rq_out_data.found_handle;
   assign rsp_hash_out     = rq_out_data.hash;
   assign rsp_entry_count  = rq_out_data.entry_count;

endmodule

FILE: design/hkst_checker.sv
// ----------------------------------------------------------------------------
// Hashed key sorted table checker
// Port-level checks on the response side of the unit.
// ----------------------------------------------------------------------------
module hkst_checker
   import hkst_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_status,
   input logic [8:0]  rsp_position,
   input logic [15:0] rsp_found_handle,
   input logic [63:0] rsp_hash_out,
   input logic [8:0]  rsp_entry_count
);

   // No response is pending right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response pending after reset");

   // A waiting response is not withdrawn.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("response withdrawn before pop");

   // A clear response reports an empty table and zero fields.
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_CLEARED) |->
      (rsp_entry_count == 9'd0 && rsp_hash_out == 64'd0 && rsp_position == 9'd0))
      else $error("clear response carries nonzero fields");

   // Only a hit returns a handle, and a hit needs a nonempty table.
   a_handle_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != ST_HIT) |-> rsp_found_handle == 16'd0)
      else $error("handle returned without a hit");

   a_hit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == ST_HIT) |-> rsp_entry_count != 9'd0)
      else $error("hit reported on an empty table");

endmodule

bind hashed_key_sorted_table_unit hkst_checker u_hkst_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_status      (rsp_status),
   .rsp_position    (rsp_position),
   .rsp_found_handle(rsp_found_handle),
   .rsp_hash_out    (rsp_hash_out),
   .rsp_entry_count (rsp_entry_count)
);
